FILE: rtl/palette_shade_table_generator_macros.svh
// assertion macros for the palette shade table generator checker
// used by psg_checker only; expects a clock named clk and a reset named rst
`ifndef PALETTE_SHADE_TABLE_GENERATOR_MACROS_SVH
`define PALETTE_SHADE_TABLE_GENERATOR_MACROS_SVH

// checked outside reset only
`define PSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/psg_pkg.sv
// shared types, codes and constants of the palette shade table generator
// no dependencies
`default_nettype none

package psg_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int DIST_W      = 18;
  localparam logic [DIST_W-1:0] DIST_BOUND = 18'd200000;
  localparam int FADE_EXTRA  = 8;
  localparam int NUM_W       = 15;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int LEVEL_W     = 6;

  localparam logic [1:0] REG_DEST_RED   = 2'd0;
  localparam logic [1:0] REG_DEST_GREEN = 2'd1;
  localparam logic [1:0] REG_DEST_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MATCH = 2'd1,
    OP_SHADE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] idx;
    rgb_t             rgb;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rgb_t              data;
  } pal_wr_t;

  function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psg_front.sv
// front end: accepts requests, drops unused opcodes, queues the rest
// depends on psg_pkg
`default_nettype none

module psg_front import psg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        request_valid,
  output logic             request_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  item_t               fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wptr;
  logic [FIFO_AW-1:0]  rptr;
  logic [FIFO_AW:0]    count;
  logic                push;
  item_t               in_item;

  assign request_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_item.op    = op_t'(opcode);
  assign in_item.idx   = entry_index;
  assign in_item.rgb   = '{r: red, g: green, b: blue};
  assign push          = request_valid && request_ready && (in_item.op != OP_NONE);

  assign q_valid = (count != '0);
  assign q_item  = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psg_palette.sv
// palette store: 256 rgb entries, one write and one registered read port
// entries never written read as zero through per-entry valid bits; depends on psg_pkg
`default_nettype none

module psg_palette import psg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pal_wr_t           wr,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output rgb_t                   rd_data
);

  rgb_t                   mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;
  rgb_t                   data_q;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/psg_back.sv
// back end: sequencer for load, match and shade, with fade quotient and palette scan
// depends on psg_pkg; reads and writes the palette through psg_palette
`default_nettype none

module psg_back import psg_pkg::*; #(
  parameter int SHADES          = 32,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output logic                   q_pop,
  input  wire logic [7:0]        dest_red,
  input  wire logic [7:0]        dest_green,
  input  wire logic [7:0]        dest_blue,
  output pal_wr_t                pal_wr,
  output logic [ADDR_W-1:0]      pal_rd_addr,
  input  wire rgb_t              pal_rd_data,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [LEVEL_W-1:0]     shade_level,
  output logic [7:0]             color_index,
  output logic                   last
);

  localparam int DIV_D = SHADES + FADE_EXTRA;
  localparam logic [LEVEL_W-1:0] K_LAST   = LEVEL_W'(SHADES - 1);
  localparam logic [ADDR_W:0]    SCAN_END = (ADDR_W+1)'(PALETTE_ENTRIES);
  localparam int     RECIP_SH   = NUM_W + $clog2(DIV_D);
  localparam longint RECIP_FULL = ((longint'(1) <<< RECIP_SH) + longint'(DIV_D) - 1)
                                  / longint'(DIV_D);
  localparam logic [NUM_W:0] RECIP_M = (NUM_W+1)'(RECIP_FULL);
  localparam int     PROD_W     = 2 * NUM_W + 1;

  st_t                state;
  st_t                state_next;
  logic               shade_mode;
  rgb_t               tgt;
  rgb_t               src;
  logic [NUM_W-1:0]   num_r, num_g, num_b;
  logic [NUM_W-1:0]   nxt_r, nxt_g, nxt_b;
  logic [NUM_W-1:0]   init_r, init_g, init_b;
  logic [PROD_W-1:0]  prod_r, prod_g, prod_b;
  logic [LEVEL_W-1:0] k;
  logic [ADDR_W:0]    icnt;
  logic               issue;
  logic               v1, v2;
  logic [ADDR_W-1:0]  idx1, idx2;
  logic [15:0]        sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]  sum_sq;
  logic [DIST_W-1:0]  best;
  logic [ADDR_W-1:0]  best_idx;
  logic               emit;
  logic               advance;

  // fade quotient: numerator times a fixed reciprocal of D, exact for 15-bit numerators
  assign prod_r = PROD_W'(num_r) * PROD_W'(RECIP_M);
  assign prod_g = PROD_W'(num_g) * PROD_W'(RECIP_M);
  assign prod_b = PROD_W'(num_b) * PROD_W'(RECIP_M);

  assign init_r = NUM_W'(pal_rd_data.r) * NUM_W'(DIV_D);
  assign init_g = NUM_W'(pal_rd_data.g) * NUM_W'(DIV_D);
  assign init_b = NUM_W'(pal_rd_data.b) * NUM_W'(DIV_D);

  // next step numerator: c*(D-k) + k*dest
  assign nxt_r = num_r + NUM_W'(dest_red)   - NUM_W'(src.r);
  assign nxt_g = num_g + NUM_W'(dest_green) - NUM_W'(src.g);
  assign nxt_b = num_b + NUM_W'(dest_blue)  - NUM_W'(src.b);

  assign issue  = (state == ST_SCAN) && (icnt < SCAN_END);
  assign sum_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    pal_wr      = '0;
    pal_rd_addr = icnt[ADDR_W-1:0];
    emit        = 1'b0;
    advance     = 1'b0;
    case (state)
      ST_IDLE: begin
        pal_rd_addr = q_item.idx;
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_LOAD: begin
              pal_wr.en   = 1'b1;
              pal_wr.addr = q_item.idx;
              pal_wr.data = q_item.rgb;
            end
            OP_MATCH: state_next = ST_SCAN;
            OP_SHADE: state_next = ST_SETUP;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: state_next = ST_DIV;
      ST_DIV: state_next = ST_SCAN;
      ST_SCAN: begin
        if (icnt == SCAN_END && !v1 && !v2) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!result_valid || result_ready) begin
          emit = 1'b1;
          if (shade_mode && k != K_LAST) begin
            advance    = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // scan pipeline: palette read, squared differences, sum and compare
  always_ff @(posedge clk) begin
    idx1 <= icnt[ADDR_W-1:0];
    idx2 <= idx1;
    sq_r <= sq_diff(tgt.r, pal_rd_data.r);
    sq_g <= sq_diff(tgt.g, pal_rd_data.g);
    sq_b <= sq_diff(tgt.b, pal_rd_data.b);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          shade_mode <= (q_item.op == OP_SHADE);
          tgt        <= q_item.rgb;
          k          <= '0;
          icnt       <= '0;
          best       <= DIST_BOUND;
        end
      end
      ST_SETUP: begin
        src   <= pal_rd_data;
        num_r <= init_r;
        num_g <= init_g;
        num_b <= init_b;
      end
      ST_DIV: begin
        tgt.r <= prod_r[RECIP_SH +: 8];
        tgt.g <= prod_g[RECIP_SH +: 8];
        tgt.b <= prod_b[RECIP_SH +: 8];
        icnt  <= '0;
        best  <= DIST_BOUND;
      end
      ST_SCAN: begin
        if (issue) begin
          icnt <= icnt + 1'b1;
        end
        if (v2 && sum_sq < best) begin
          best     <= sum_sq;
          best_idx <= idx2;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          shade_level <= k;
          color_index <= best_idx;
          last        <= !shade_mode || (k == K_LAST);
        end
        if (advance) begin
          k     <= k + 1'b1;
          num_r <= nxt_r;
          num_g <= nxt_g;
          num_b <= nxt_b;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/palette_shade_table_generator.sv
// top level of the palette shade table generator: config registers and wiring
// depends on psg_pkg, psg_front, psg_palette, psg_back
//
// channel   | handshake                   | payload
// ----------+-----------------------------+-----------------------------------------
// request   | request_valid/request_ready | opcode, entry_index, red, green, blue
// result    | result_valid/result_ready   | shade_level, color_index, last
// config    | cfg_we                      | cfg_index, cfg_data
//
// load: written to the palette straight from idle; match: one scan of PALETTE_ENTRIES entries
// shade: a setup step, then for each of SHADES steps a fade quotient, a full scan and an emit
// the single palette read port is scanned one entry per cycle during each scan
// requests queue four deep while the back end works; a stalled result holds the back end
// synchronous reset clears the palette valid bits, the queue and the fade target
`default_nettype none

module palette_shade_table_generator import psg_pkg::*; #(
  parameter int SHADES          = 32,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               request_valid,
  output logic                    request_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic [7:0]         entry_index,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [LEVEL_W-1:0]      shade_level,
  output logic [7:0]              color_index,
  output logic                    last,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  logic [7:0]        dest_red, dest_green, dest_blue;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  pal_wr_t           pal_wr;
  logic [ADDR_W-1:0] pal_rd_addr;
  rgb_t              pal_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_red   <= '0;
      dest_green <= '0;
      dest_blue  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEST_RED:   dest_red   <= cfg_data;
        REG_DEST_GREEN: dest_green <= cfg_data;
        REG_DEST_BLUE:  dest_blue  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  psg_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr      (pal_wr),
    .rd_addr (pal_rd_addr),
    .rd_data (pal_rd_data)
  );

  psg_back #(
    .SHADES          (SHADES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .dest_red     (dest_red),
    .dest_green   (dest_green),
    .dest_blue    (dest_blue),
    .pal_wr       (pal_wr),
    .pal_rd_addr  (pal_rd_addr),
    .pal_rd_data  (pal_rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .shade_level  (shade_level),
    .color_index  (color_index),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: rtl/psg_checker.sv
// port-level checks on the result channel of the palette shade table generator
// uses palette_shade_table_generator_macros.svh; bound to the top level below
`default_nettype none
`include "palette_shade_table_generator_macros.svh"

module psg_checker #(
  parameter int SHADES = 32
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic [5:0] shade_level,
  input wire logic [7:0] color_index,
  input wire logic       last
);

  localparam logic [5:0] K_LAST = 6'(SHADES - 1);

  `PSG_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(color_index) && $stable(shade_level) && $stable(last), "stalled result changed")
  `PSG_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid, "result valid right after reset")
  `PSG_ASSERT(a_last_level, result_valid && last && shade_level != 6'd0 |-> shade_level == K_LAST, "last flag on a middle shade step")
  `PSG_ASSERT(a_mid_level, result_valid && !last |-> shade_level != K_LAST, "final shade step without last flag")

endmodule

bind palette_shade_table_generator psg_checker #(.SHADES(SHADES)) u_psg_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .shade_level  (shade_level),
  .color_index  (color_index),
  .last         (last)
);

`default_nettype wire
